// File: src/depq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the double-ended priority queue.
// No dependencies; every other file refers to it by scoped names.
package depq_pkg;

   localparam int CAPACITY    = 64;
   localparam int VALUE_WIDTH = 32;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [1:0]                    opcode_type;
   typedef logic [1:0]                    status_type;

   localparam opcode_type OP_INSERT    = 2'd0;
   localparam opcode_type OP_POP_LARGE = 2'd1;
   localparam opcode_type OP_POP_SMALL = 2'd2;

   localparam status_type ST_DONE  = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   // Most negative value: acts as an always-valid left neighbor for the head cell.
   localparam value_type VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   // Command broadcast to every cell of a chain.
   typedef struct packed {
      logic insert;
      logic pop_head;
      logic drop_tail;
   } chain_cmd_type;

endpackage

// File: src/depq_req_if.sv
`timescale 1ns / 1ps
// Request channel: operation and value under a valid/ready handshake.
// Depends on depq_pkg.
interface depq_req_if;
   logic                 valid;
   logic                 ready;
   depq_pkg::opcode_type operation;
   depq_pkg::value_type  value;

   modport source (output valid, output operation, output value, input ready);
   modport sink (input valid, input operation, input value, output ready);
endinterface

// File: src/depq_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: popped value and status under a valid/ready handshake.
// Depends on depq_pkg.
interface depq_rsp_if;
   logic                 valid;
   logic                 ready;
   depq_pkg::value_type  popped_value;
   depq_pkg::status_type status;

   modport source (output valid, output popped_value, output status, input ready);
   modport sink (input valid, input popped_value, input status, output ready);
endinterface

// File: src/depq_cell.sv
`timescale 1ns / 1ps
// One slot of a sorted chain: holds a value and its valid bit, and trades
// data with its left and right neighbors. Depends on depq_pkg.
module depq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  depq_pkg::chain_cmd_type cmd,
   input  depq_pkg::value_type    new_value,
   input  logic                   prev_valid,
   input  depq_pkg::value_type    prev_value,
   input  logic                   next_valid,
   input  depq_pkg::value_type    next_value,
   output logic                   valid,
   output depq_pkg::value_type    value
);

   logic                valid_ff, valid_in;
   depq_pkg::value_type value_ff, value_in;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      priority if (cmd.insert) begin
         // Ascending order; equal values stay ahead of the new one.
         priority if (valid_ff && (value_ff <= new_value)) begin
            valid_in = valid_ff;
         end else if (prev_valid && (prev_value > new_value)) begin
            valid_in = 1'b1;
            value_in = prev_value;
         end else if (valid_ff || prev_valid) begin
            valid_in = 1'b1;
            value_in = new_value;
         end else begin
            valid_in = valid_ff;
         end
      end else if (cmd.pop_head) begin
         valid_in = next_valid;
         value_in = next_value;
      end else if (cmd.drop_tail) begin
         if (valid_ff && !next_valid) begin
            valid_in = 1'b0;
         end
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;

endmodule

// File: src/depq_chain.sv
`timescale 1ns / 1ps
// Row of depq_cell slots kept in ascending order from the head.
// Depends on depq_pkg and depq_cell.
module depq_chain #(
   parameter int CAPACITY = depq_pkg::CAPACITY
) (
   input  logic                    clock,
   input  logic                    reset,
   input  depq_pkg::chain_cmd_type cmd,
   input  depq_pkg::value_type     new_value,
   output depq_pkg::value_type     head_value
);

   logic                valid [CAPACITY];
   depq_pkg::value_type value [CAPACITY];

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic                pv, nv;
         depq_pkg::value_type pval, nval;

         if (i == 0) begin : g_head
            assign pv   = 1'b1;
            assign pval = depq_pkg::VALUE_MIN;
         end else begin : g_body
            assign pv   = valid[i-1];
            assign pval = value[i-1];
         end

         if (i == CAPACITY - 1) begin : g_tail
            assign nv   = 1'b0;
            assign nval = value[i];
         end else begin : g_inner
            assign nv   = valid[i+1];
            assign nval = value[i+1];
         end

         depq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .new_value  (new_value),
            .prev_valid (pv),
            .prev_value (pval),
            .next_valid (nv),
            .next_value (nval),
            .valid      (valid[i]),
            .value      (value[i])
         );
      end
   endgenerate

   assign head_value = value[0];

endmodule

// File: src/double_ended_priority_queue.sv
`timescale 1ns / 1ps
// Double-ended priority queue: a bounded multiset of signed 32-bit values.
// Requests arrive on req_chan (operation, value): insert, pop largest, pop
// smallest. Each request yields exactly one response on rsp_chan
// (popped_value, status): done, empty on a pop of an empty store, full on an
// insert into a full store. Code 3 is a no-op answered with done.
// The store is two chains of CAPACITY cells. One holds the values in
// ascending order, the other their bitwise complements in ascending order,
// so the minimum and the maximum both sit in a head cell. Every cell
// compares against the request value in parallel, so one request is taken
// per cycle; its response is registered and appears in the cycle after the
// transfer. The response register is the only buffer: while the receiver
// stalls with a response pending, req_chan.ready stays low.
// Reset (synchronous) empties the store and drops any pending response;
// no clearing pass is needed, the valid bits of the cells clear at once.
// Depends on depq_pkg, depq_req_if, depq_rsp_if, depq_chain and depq_cell.
module double_ended_priority_queue #(
   parameter int CAPACITY = depq_pkg::CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   depq_req_if.sink    req_chan,
   depq_rsp_if.source  rsp_chan
);

   localparam int CountWidth = $clog2(CAPACITY + 1);

   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   depq_pkg::value_type     popped_ff, popped_in;
   depq_pkg::status_type    status_ff, status_in;
   depq_pkg::chain_cmd_type asc_cmd, dsc_cmd;
   depq_pkg::value_type     asc_head, dsc_head;
   logic                    take, is_empty, is_full;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign take           = req_chan.valid && req_chan.ready;
   assign is_empty       = (count_ff == '0);
   assign is_full        = (count_ff == CountWidth'(CAPACITY));

   always_comb begin
      asc_cmd   = '0;
      dsc_cmd   = '0;
      count_in  = count_ff;
      popped_in = popped_ff;
      status_in = status_ff;
      if (take) begin
         popped_in = '0;
         status_in = depq_pkg::ST_DONE;
         unique case (req_chan.operation)
            depq_pkg::OP_INSERT: begin
               if (is_full) begin
                  status_in = depq_pkg::ST_FULL;
               end else begin
                  asc_cmd.insert = 1'b1;
                  dsc_cmd.insert = 1'b1;
                  count_in       = count_ff + 1'b1;
               end
            end
            depq_pkg::OP_POP_LARGE: begin
               if (is_empty) begin
                  status_in = depq_pkg::ST_EMPTY;
               end else begin
                  popped_in         = ~dsc_head;
                  dsc_cmd.pop_head  = 1'b1;
                  asc_cmd.drop_tail = 1'b1;
                  count_in          = count_ff - 1'b1;
               end
            end
            depq_pkg::OP_POP_SMALL: begin
               if (is_empty) begin
                  status_in = depq_pkg::ST_EMPTY;
               end else begin
                  popped_in         = asc_head;
                  asc_cmd.pop_head  = 1'b1;
                  dsc_cmd.drop_tail = 1'b1;
                  count_in          = count_ff - 1'b1;
               end
            end
            default: begin
               status_in = depq_pkg::ST_DONE;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      popped_ff <= popped_in;
      status_ff <= status_in;
   end

   // Ascending chain holds the values as they are.
   depq_chain #(
      .CAPACITY (CAPACITY)
   ) u_asc_chain (
      .clock      (clock),
      .reset      (reset),
      .cmd        (asc_cmd),
      .new_value  (req_chan.value),
      .head_value (asc_head)
   );

   // Complement reverses signed order, so this chain's head is the maximum.
   depq_chain #(
      .CAPACITY (CAPACITY)
   ) u_dsc_chain (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dsc_cmd),
      .new_value  (~req_chan.value),
      .head_value (dsc_head)
   );

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.popped_value = popped_ff;
   assign rsp_chan.status       = status_ff;

endmodule

// File: verif/depq_checker.sv
`timescale 1ns / 1ps
// Checker for the double-ended priority queue: watches both channels, keeps a
// sorted copy of the store and compares every response transfer with its prediction.
// Depends on depq_pkg.
module depq_checker #(
   parameter int CAPACITY = depq_pkg::CAPACITY
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  depq_pkg::opcode_type req_operation,
   input  depq_pkg::value_type  req_value,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  depq_pkg::value_type  rsp_popped_value,
   input  depq_pkg::status_type rsp_status,
   input  logic                 end_of_test,
   output int                   fail_count,
   output int                   outstanding
);

   typedef struct {
      depq_pkg::value_type  popped_value;
      depq_pkg::status_type status;
   } answer_type;

   depq_pkg::value_type held_values[$];   // ascending signed order
   answer_type          answers_due[$];
   bit                  closed;

   initial begin
      fail_count  = 0;
      outstanding = 0;
      closed      = 0;
   end

   task automatic report_mismatch(string what);
      $display("ERROR at %0t ns: %s", $time, what);
      fail_count++;
   endtask

   // Applies one operation to the shadow store and returns its response.
   function automatic answer_type apply_operation(depq_pkg::opcode_type op,
                                                  depq_pkg::value_type v);
      answer_type answer;
      int         pos;
      answer.popped_value = '0;
      answer.status       = depq_pkg::ST_DONE;
      case (op)
         depq_pkg::OP_INSERT: begin
            if (held_values.size() >= CAPACITY) begin
               answer.status = depq_pkg::ST_FULL;
            end else begin
               pos = held_values.size();
               while (pos > 0 && held_values[pos-1] > v)
                  pos--;
               held_values.insert(pos, v);
            end
         end
         depq_pkg::OP_POP_LARGE: begin
            if (held_values.size() == 0)
               answer.status = depq_pkg::ST_EMPTY;
            else
               answer.popped_value = held_values.pop_back();
         end
         depq_pkg::OP_POP_SMALL: begin
            if (held_values.size() == 0)
               answer.status = depq_pkg::ST_EMPTY;
            else
               answer.popped_value = held_values.pop_front();
         end
         default: ;   // unused code: no-op, answered with done
      endcase
      return answer;
   endfunction

   always @(posedge clock) begin
      answer_type due;
      if (reset) begin
         held_values.delete();
         answers_due.delete();
      end else begin
         // the response of a transfer comes later, so check before predicting
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               report_mismatch($sformatf("response with none expected: value %0d status %0d",
                                         rsp_popped_value, rsp_status));
            end else begin
               due = answers_due.pop_front();
               if (rsp_popped_value !== due.popped_value)
                  report_mismatch($sformatf("popped_value got %0d want %0d",
                                            rsp_popped_value, due.popped_value));
               if (rsp_status !== due.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_status, due.status));
            end
         end
         if (req_valid && req_ready)
            answers_due.push_back(apply_operation(req_operation, req_value));
         if (end_of_test && !closed) begin
            closed = 1;
            while (answers_due.size() != 0) begin
               due = answers_due.pop_front();
               report_mismatch($sformatf("response never came: value %0d status %0d",
                                         due.popped_value, due.status));
            end
         end
      end
      outstanding = answers_due.size();
   end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Top of the double-ended priority queue testbench: clock, reset, request and
// response drivers, watchdog and verdict. Depends on depq_pkg, both channel
// interfaces, double_ended_priority_queue and depq_checker.
module tb_top;

   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 7;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int ITEM_TARGET    = 900;
   localparam int MAX_GAP        = 15;
   localparam int DRAIN_CYCLES   = 20;

   localparam depq_pkg::opcode_type OP_IDLE   = 2'd3;   // unused code, acts as a no-op
   localparam depq_pkg::value_type  VALUE_MAX = ~depq_pkg::VALUE_MIN;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic end_of_test = 1'b0;
   int   fail_count;
   int   outstanding;
   int   items_sent = 0;
   int   stall_orders = 0;
   bit   sender_relaxed = 1'b1;
   int   quiet_cycles = 0;

   always #HALF_PERIOD clock = ~clock;

   depq_req_if req_chan ();
   depq_rsp_if rsp_chan ();

   double_ended_priority_queue dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   depq_checker order_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_operation    (req_chan.operation),
      .req_value        (req_chan.value),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_popped_value (rsp_chan.popped_value),
      .rsp_status       (rsp_chan.status),
      .end_of_test      (end_of_test),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   // Values biased toward duplicates and the two ends of the range.
   function automatic depq_pkg::value_type pick_value();
      case ($urandom_range(0, 5))
         0:       return depq_pkg::value_type'(int'($urandom_range(0, 8)) - 4);
         1:       return depq_pkg::VALUE_MIN + depq_pkg::value_type'($urandom_range(0, 3));
         2:       return VALUE_MAX - depq_pkg::value_type'($urandom_range(0, 3));
         default: return depq_pkg::value_type'($urandom);
      endcase
   endfunction

   function automatic depq_pkg::opcode_type pick_pop();
      return $urandom_range(0, 1) ? depq_pkg::OP_POP_LARGE : depq_pkg::OP_POP_SMALL;
   endfunction

   // Offers one request and returns after the edge of its transfer.
   task automatic send_item(depq_pkg::opcode_type op, depq_pkg::value_type v);
      int gap;
      gap = sender_relaxed ? $urandom_range(0, MAX_GAP) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
         req_chan.value = depq_pkg::value_type'($urandom);
      end
      @(negedge clock);
      req_chan.valid     = 1'b1;
      req_chan.operation = op;
      req_chan.value     = v;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Mixed traffic; insert_pct sets the balance between inserts and pops.
   task automatic run_mix(int count, int insert_pct);
      int roll;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < 3)
            send_item(OP_IDLE, depq_pkg::value_type'($urandom));
         else if (roll < insert_pct)
            send_item(depq_pkg::OP_INSERT, pick_value());
         else
            send_item(pick_pop(), depq_pkg::value_type'($urandom));
      end
   endtask

   // Receiver: random hold-off before each transfer, in bursts with and
   // without idling, plus a long hold-off on request.
   initial begin
      int hold;
      int served;
      int burst;
      bit relaxed;
      rsp_chan.ready = 1'b0;
      served  = 0;
      burst   = 0;
      relaxed = 1'b1;
      forever begin
         if (burst == 0) begin
            burst   = $urandom_range(10, 40);
            relaxed = $urandom_range(0, 2) != 0;
         end
         burst--;
         if (stall_orders != served) begin
            served = stall_orders;
            hold   = LONG_HOLD;
         end else begin
            hold = relaxed ? $urandom_range(0, MAX_GAP) : 0;
         end
         repeat (hold) begin
            @(negedge clock);
            rsp_chan.ready = 1'b0;
         end
         @(negedge clock);
         rsp_chan.ready = 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_chan.valid     = 1'b0;
      req_chan.operation = depq_pkg::OP_INSERT;
      req_chan.value     = '0;
      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty store, extremes, duplicates, no-op, both pop ends
      send_item(depq_pkg::OP_POP_SMALL, '0);
      send_item(depq_pkg::OP_POP_LARGE, VALUE_MAX);
      send_item(OP_IDLE, depq_pkg::VALUE_MIN);
      send_item(depq_pkg::OP_INSERT, VALUE_MAX);
      send_item(depq_pkg::OP_INSERT, depq_pkg::VALUE_MIN);
      send_item(depq_pkg::OP_INSERT, '0);
      send_item(depq_pkg::OP_INSERT, -1);
      send_item(depq_pkg::OP_INSERT, 1);
      send_item(depq_pkg::OP_INSERT, 7);
      send_item(depq_pkg::OP_INSERT, 7);
      send_item(depq_pkg::OP_INSERT, -7);
      send_item(depq_pkg::OP_INSERT, depq_pkg::VALUE_MIN);
      send_item(OP_IDLE, VALUE_MAX);
      send_item(depq_pkg::OP_POP_LARGE, '0);
      send_item(depq_pkg::OP_POP_SMALL, '0);
      send_item(depq_pkg::OP_POP_SMALL, '0);
      send_item(depq_pkg::OP_POP_LARGE, '0);
      send_item(depq_pkg::OP_POP_LARGE, '0);
      send_item(depq_pkg::OP_POP_SMALL, '0);
      send_item(depq_pkg::OP_POP_SMALL, '0);
      send_item(depq_pkg::OP_POP_LARGE, '0);
      send_item(depq_pkg::OP_POP_SMALL, '0);
      send_item(depq_pkg::OP_POP_LARGE, '0);
      send_item(depq_pkg::OP_POP_SMALL, '0);

      // long receiver hold-off while requests keep coming back to back
      sender_relaxed = 1'b0;
      stall_orders++;
      run_mix(30, 70);
      wait_quiet();

      // fill past capacity, then drain past empty
      sender_relaxed = 1'b1;
      repeat (depq_pkg::CAPACITY + 4) send_item(depq_pkg::OP_INSERT, pick_value());
      repeat (depq_pkg::CAPACITY + 4) send_item(pick_pop(), depq_pkg::value_type'($urandom));

      while (items_sent < ITEM_TARGET) begin
         sender_relaxed = $urandom_range(0, 3) != 0;
         case ($urandom_range(0, 7))
            0: repeat (depq_pkg::CAPACITY + $urandom_range(0, 4))
                  send_item(depq_pkg::OP_INSERT, pick_value());
            1: repeat (depq_pkg::CAPACITY + $urandom_range(0, 4))
                  send_item(pick_pop(), '0);
            2: wait_quiet();
            3: run_mix($urandom_range(20, 60), 85);
            4: run_mix($urandom_range(20, 60), 25);
            default: run_mix($urandom_range(20, 60), $urandom_range(40, 60));
         endcase
      end

      @(negedge clock);
      req_chan.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      end_of_test = 1'b1;
      @(posedge clock);
      @(negedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
